[hw/rtl/bol_pkg.sv]
// Shared definitions for the bounded ordered list: command codes, field widths
// and the control word broadcast along the cell row.
// No dependencies.
package bol_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int CMD_W        = 4;
  localparam int POS_W        = 5;
  localparam int VAL_W        = 32;
  localparam int CNT_W        = 5;
  localparam int GRP          = 8;  // match bits examined per scan cycle

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 4'd0,
    CMD_PUSH_BACK  = 4'd1,
    CMD_INSERT     = 4'd2,
    CMD_POP_FRONT  = 4'd3,
    CMD_POP_BACK   = 4'd4,
    CMD_ERASE      = 4'd5,
    CMD_REMOVE     = 4'd6,
    CMD_READ       = 4'd7,
    CMD_CONTAINS   = 4'd8,
    CMD_CLEAR      = 4'd9
  } cmd_t;

  typedef struct packed {
    logic ins;  // open a gap at pos and write the new word there
    logic del;  // close the gap at pos
  } cell_ctl_t;

endpackage

[hw/rtl/bol_cell.sv]
// One slot of the list: holds a single word, shifts toward either neighbor,
// and reports an equality match always, and its word only when addressed.
// Depends on bol_pkg.
module bol_cell #(
  parameter int IW  = 4,
  parameter int IDX = 0
) (
  input  logic                               clk,
  input  bol_pkg::cell_ctl_t                 ctl,
  input  logic [IW-1:0]                      pos,
  input  logic signed [bol_pkg::VAL_W-1:0]   wr_value,
  input  logic signed [bol_pkg::VAL_W-1:0]   left_value,
  input  logic signed [bol_pkg::VAL_W-1:0]   right_value,
  input  logic signed [bol_pkg::VAL_W-1:0]   key,
  output logic signed [bol_pkg::VAL_W-1:0]   value,
  output logic                               match,
  output logic signed [bol_pkg::VAL_W-1:0]   sel_value
);
  import bol_pkg::*;

  localparam logic [IW-1:0] MY_IDX = IW'(IDX);

  logic signed [VAL_W-1:0] value_r;
  logic signed [VAL_W-1:0] value_nxt;
  logic                    at_pos;
  logic                    above_pos;

  assign at_pos    = (pos == MY_IDX);
  assign above_pos = (MY_IDX > pos);

  always_comb begin
    value_nxt = value_r;
    if (ctl.ins) begin
      if (at_pos) begin
        value_nxt = wr_value;
      end else if (above_pos) begin
        value_nxt = left_value;
      end
    end else if (ctl.del && (at_pos || above_pos)) begin
      value_nxt = right_value;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign value     = value_r;
  assign match     = (value_r == key);
  assign sel_value = at_pos ? value_r : '0;

endmodule

[hw/rtl/bounded_ordered_list.sv]
// Top level of the bounded ordered list: a row of bol_cell slots, the command
// decoder, the first-match scan and the output word register.
// Depends on bol_pkg and bol_cell.
//
//   channel  direction  handshake          payload
//   in       sink       in_valid/in_stall  in_cmd, in_position, in_item_value
//   out      source     out_valid/out_stall out_ok, out_read_value, out_count
//
// Push, insert, pop, erase, read, clear and unknown commands finish in ST_IDLE,
// registering their result word directly; all slots shift in parallel.
// Remove and contains: the match vector is captured into hit_r, then scanned
// 8 slots per cycle for the lowest hit; ST_DONE writes the result once out is free.
// Reset clears the count and control; slot contents are not cleared.
// A word waits in the output register while out_stall is high; a new word is
// taken in the same cycle the previous result leaves.
module bounded_ordered_list #(
  parameter int CAPACITY = bol_pkg::CAPACITY_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [bol_pkg::CMD_W-1:0]          in_cmd,
  input  logic [bol_pkg::POS_W-1:0]          in_position,
  input  logic signed [bol_pkg::VAL_W-1:0]   in_item_value,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               out_ok,
  output logic signed [bol_pkg::VAL_W-1:0]   out_read_value,
  output logic [bol_pkg::CNT_W-1:0]          out_count
);
  import bol_pkg::*;

  localparam int IW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int LW   = $clog2(CAPACITY + 1);
  localparam int CW   = (LW > POS_W) ? LW : POS_W;
  localparam int NGRP = (CAPACITY + GRP - 1) / GRP;
  localparam int GW   = (NGRP > 1) ? $clog2(NGRP) : 1;
  localparam int HW   = NGRP * GRP;
  localparam int PW   = $clog2(GRP);

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DONE} state_t;

  state_t                  state_r, state_nxt;
  logic [LW-1:0]           len_r, len_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic                    out_ok_r, out_ok_nxt;
  logic signed [VAL_W-1:0] out_rv_r, out_rv_nxt;
  logic [CNT_W-1:0]        out_cnt_r, out_cnt_nxt;
  logic [HW-1:0]           hit_r, hit_nxt;
  logic [GW-1:0]           grp_r, grp_nxt;
  logic                    found_r, found_nxt;
  logic [IW-1:0]           fidx_r, fidx_nxt;
  logic                    remove_r, remove_nxt;

  logic signed [VAL_W-1:0] cell_val [CAPACITY];
  logic signed [VAL_W-1:0] cell_sel [CAPACITY];
  logic [CAPACITY-1:0]     cell_hit;
  logic [HW-1:0]           hits_now;
  logic signed [VAL_W-1:0] rd_value;
  cell_ctl_t               ctl;
  logic [IW-1:0]           p_sel;
  logic                    out_free;
  logic                    in_fire;
  logic [GRP-1:0]          grp_bits;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != ST_IDLE) || !out_free;
  assign in_fire  = in_valid && !in_stall;

  // Slot row
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [VAL_W-1:0] left_v;
    logic signed [VAL_W-1:0] right_v;
    if (i == 0) begin : g_first
      assign left_v = in_item_value;
    end else begin : g_mid_l
      assign left_v = cell_val[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_v = cell_val[i];
    end else begin : g_mid_r
      assign right_v = cell_val[i+1];
    end
    bol_cell #(.IW(IW), .IDX(i)) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .pos        (p_sel),
      .wr_value   (in_item_value),
      .left_value (left_v),
      .right_value(right_v),
      .key        (in_item_value),
      .value      (cell_val[i]),
      .match      (cell_hit[i]),
      .sel_value  (cell_sel[i])
    );
    assign hits_now[i] = cell_hit[i] && (LW'(i) < len_r);
  end

  if (HW > CAPACITY) begin : g_pad
    assign hits_now[HW-1:CAPACITY] = '0;
  end

  always_comb begin
    rd_value = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_value = rd_value | cell_sel[i];
    end
  end

  // Slot address for the current command
  always_comb begin
    p_sel = '0;
    if (state_r == ST_DONE) begin
      p_sel = fidx_r;
    end else begin
      case (cmd_t'(in_cmd))
        CMD_PUSH_BACK: p_sel = IW'(len_r);
        CMD_POP_BACK:  p_sel = IW'(len_r - 1'b1);
        CMD_INSERT, CMD_ERASE, CMD_READ: p_sel = IW'(in_position);
        default:       p_sel = '0;
      endcase
    end
  end

  assign grp_bits = hit_r[grp_r*GRP +: GRP];

  always_comb begin
    logic             full;
    logic             empty;
    logic [CW-1:0]    pos_c;
    logic [CW-1:0]    len_c;
    logic             ok_v;
    logic signed [VAL_W-1:0] rv_v;
    logic [LW-1:0]    len_v;
    logic             go_scan;
    logic [PW-1:0]    pe;

    full    = (len_r == LW'(CAPACITY));
    empty   = (len_r == '0);
    pos_c   = CW'(in_position);
    len_c   = CW'(len_r);
    ok_v    = 1'b0;
    rv_v    = '0;
    len_v   = len_r;
    go_scan = 1'b0;
    pe      = '0;

    state_nxt     = state_r;
    len_nxt       = len_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_ok_nxt    = out_ok_r;
    out_rv_nxt    = out_rv_r;
    out_cnt_nxt   = out_cnt_r;
    hit_nxt       = hit_r;
    grp_nxt       = grp_r;
    found_nxt     = found_r;
    fidx_nxt      = fidx_r;
    remove_nxt    = remove_r;
    ctl           = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          case (cmd_t'(in_cmd))
            CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
              if (!full) begin
                ok_v    = 1'b1;
                ctl.ins = 1'b1;
                len_v   = LW'(len_r + 1'b1);
              end
            end
            CMD_INSERT: begin
              if (!full && (pos_c <= len_c)) begin
                ok_v    = 1'b1;
                ctl.ins = 1'b1;
                len_v   = LW'(len_r + 1'b1);
              end
            end
            CMD_POP_FRONT, CMD_POP_BACK: begin
              if (!empty) begin
                ok_v    = 1'b1;
                ctl.del = 1'b1;
                rv_v    = rd_value;
                len_v   = LW'(len_r - 1'b1);
              end
            end
            CMD_ERASE: begin
              if (pos_c < len_c) begin
                ok_v    = 1'b1;
                ctl.del = 1'b1;
                len_v   = LW'(len_r - 1'b1);
              end
            end
            CMD_READ: begin
              if (pos_c < len_c) begin
                ok_v = 1'b1;
                rv_v = rd_value;
              end
            end
            CMD_REMOVE, CMD_CONTAINS: begin
              go_scan = 1'b1;
            end
            CMD_CLEAR: begin
              ok_v  = 1'b1;
              len_v = '0;
            end
            default: begin
              ok_v = 1'b0;
            end
          endcase
          if (go_scan) begin
            state_nxt  = ST_SCAN;
            hit_nxt    = hits_now;
            grp_nxt    = '0;
            remove_nxt = (cmd_t'(in_cmd) == CMD_REMOVE);
          end else begin
            len_nxt       = len_v;
            out_valid_nxt = 1'b1;
            out_ok_nxt    = ok_v;
            out_rv_nxt    = rv_v;
            out_cnt_nxt   = CNT_W'(len_v);
          end
        end
      end
      ST_SCAN: begin
        for (int k = GRP - 1; k >= 0; k--) begin
          if (grp_bits[k]) begin
            pe = PW'(k);
          end
        end
        if (|grp_bits) begin
          found_nxt = 1'b1;
          fidx_nxt  = IW'({grp_r, pe});
          state_nxt = ST_DONE;
        end else if (grp_r == GW'(NGRP - 1)) begin
          found_nxt = 1'b0;
          state_nxt = ST_DONE;
        end else begin
          grp_nxt = GW'(grp_r + 1'b1);
        end
      end
      ST_DONE: begin
        if (out_free) begin
          if (found_r && remove_r) begin
            ctl.del = 1'b1;
            len_v   = LW'(len_r - 1'b1);
          end
          len_nxt       = len_v;
          out_valid_nxt = 1'b1;
          out_ok_nxt    = found_r;
          out_rv_nxt    = '0;
          out_cnt_nxt   = CNT_W'(len_v);
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    out_ok_r  <= out_ok_nxt;
    out_rv_r  <= out_rv_nxt;
    out_cnt_r <= out_cnt_nxt;
    hit_r     <= hit_nxt;
    grp_r     <= grp_nxt;
    found_r   <= found_nxt;
    fidx_r    <= fidx_nxt;
    remove_r  <= remove_nxt;
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      len_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_ok         = out_ok_r;
  assign out_read_value = out_rv_r;
  assign out_count      = out_cnt_r;

endmodule

[hw/rtl/bol_checker.sv]
// Port-level checks for bounded_ordered_list, attached by bind.
// Depends on bol_pkg.
module bol_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_stall,
  input logic [bol_pkg::CMD_W-1:0]          in_cmd,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic                               out_ok,
  input logic signed [bol_pkg::VAL_W-1:0]   out_read_value,
  input logic [bol_pkg::CNT_W-1:0]          out_count
);
  import bol_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_read_value) && $stable(out_count)
      && $stable(out_ok))
    else $error("result word changed while stalled");

  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> in_stall)
    else $error("input taken while result word is blocked");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ok |-> out_read_value == '0)
    else $error("failed command returned a value");

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_cmd == CMD_CLEAR |=> out_valid && out_ok && out_count == '0)
    else $error("clear did not empty the list");

  a_unknown: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_cmd > CMD_CLEAR |=> out_valid && !out_ok)
    else $error("unknown command reported success");

endmodule

bind bounded_ordered_list bol_checker u_bol_checker (.*);
